/* hw/rtl/tsc_pkg.sv */
// ============================================================================
// tsc_pkg - shared types and constants for trajectory smoothing correction
// Widths, sequencer states, read tags and the control/status structs that
// pass between the sequencer and the datapath.
// ============================================================================
`default_nettype none

package tsc_pkg;

    // Field and trajectory widths
    localparam int SHIFT_W = 32;
    localparam int CUM_W   = 48;
    localparam int SUM_W   = 54;
    localparam int OUT_W   = 32;
    localparam int NUM_CH  = 3;

    // Ring geometry
    localparam int RING_DEPTH = 64;
    localparam int ADDR_W     = 6;
    localparam int WORD_W     = NUM_CH * CUM_W;

    // Frame counter saturates at its all-ones value
    localparam int FS_W = 7;

    // Radius register and its limit
    localparam int RAD_W = 5;
    localparam logic [RAD_W-1:0] RADIUS_RESET = 5'd30;
    localparam logic [FS_W-1:0]  MAX_RADIUS   = 7'd31;

    // Divider: one quotient bit per cycle over the full sum width
    localparam int DIV_BITS = SUM_W;
    localparam int CNT_W    = 6;
    localparam int DVS_W    = 6;

    // Channel select codes
    localparam logic [1:0] CH_X = 2'd0;
    localparam logic [1:0] CH_Y = 2'd1;
    localparam logic [1:0] CH_A = 2'd2;

    localparam logic signed [CUM_W-1:0] CUM_MAX = {1'b0, {(CUM_W-1){1'b1}}};
    localparam logic signed [CUM_W-1:0] CUM_MIN = {1'b1, {(CUM_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PLAN,
        ST_SETUP,
        ST_SUM,
        ST_PREV,
        ST_DRAIN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    // What a ring read is for
    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_SUM,
        TAG_PREV
    } tag_t;

    typedef struct packed {
        logic              cap_in;
        logic              seq_clear;
        logic              clr_acc;
        logic              rd_en;
        tag_t              rd_tag;
        logic [ADDR_W-1:0] rd_back;
        logic [DVS_W-1:0]  count;
        logic              div_start;
        logic [1:0]        ch;
        logic              res_load;
        logic              out_load;
        logic              out_last;
    } ctl_t;

    typedef struct packed {
        logic [FS_W-1:0] frames_seen;
        logic            div_done;
    } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/tsc_divider.sv */
// ============================================================================
// tsc_divider - iterative restoring divider
// Unsigned dividend over a small nonzero divisor, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module tsc_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [tsc_pkg::SUM_W-1:0]    dividend,
    input  wire logic [tsc_pkg::DVS_W-1:0]    divisor,
    output logic                              done,
    output logic [tsc_pkg::SUM_W-1:0]         quotient
);
    import tsc_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [DVS_W:0]      trial;
    logic [DVS_W:0]      diff;
    logic                ge;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_BITS - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* hw/rtl/tsc_datapath.sv */
// ============================================================================
// tsc_datapath - trajectory rings, window sums and correction
// Holds the cumulative trajectory, the ring of recent points, the window
// accumulators, the shared divider and the output payload registers.
// ============================================================================
`default_nettype none

module tsc_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tsc_pkg::ctl_t                      ctl,
    input  wire logic signed [tsc_pkg::SHIFT_W-1:0] shift_x,
    input  wire logic signed [tsc_pkg::SHIFT_W-1:0] shift_y,
    input  wire logic signed [tsc_pkg::SHIFT_W-1:0] rotation,
    output tsc_pkg::sts_t                           sts,
    output logic signed [tsc_pkg::OUT_W-1:0]        corrected_x,
    output logic signed [tsc_pkg::OUT_W-1:0]        corrected_y,
    output logic signed [tsc_pkg::OUT_W-1:0]        corrected_rotation,
    output logic                                    end_of_run
);
    import tsc_pkg::*;

    logic signed [CUM_W-1:0]   cum_reg  [NUM_CH];
    logic signed [CUM_W-1:0]   cum_next [NUM_CH];
    logic signed [SHIFT_W-1:0] shift_in [NUM_CH];
    logic signed [SUM_W-1:0]   sum_reg  [NUM_CH];
    logic signed [CUM_W-1:0]   prev_reg [NUM_CH];
    logic signed [OUT_W-1:0]   res_reg  [NUM_CH];
    logic signed [OUT_W-1:0]   out_reg  [NUM_CH];
    logic                      last_reg;
    logic [FS_W-1:0]           fs_reg;
    logic [ADDR_W-1:0]         wp_reg;

    logic [WORD_W-1:0]         ring [RING_DEPTH];
    logic [WORD_W-1:0]         rd_data_reg;
    tag_t                      tag_reg;
    logic [ADDR_W-1:0]         rd_addr;
    logic [WORD_W-1:0]         wr_data;

    logic signed [SUM_W-1:0]   sel_sum;
    logic signed [CUM_W-1:0]   sel_prev;
    logic [SUM_W-1:0]          mag;
    logic [SUM_W-1:0]          dividend;
    logic                      div_done;
    logic [SUM_W-1:0]          quotient;
    logic signed [SUM_W:0]     q_signed;
    logic signed [SUM_W+1:0]   diff;
    logic signed [OUT_W-1:0]   diff_sat;

    assign shift_in[0] = shift_x;
    assign shift_in[1] = shift_y;
    assign shift_in[2] = rotation;

    // Saturating trajectory update
    always_comb
    begin
        logic signed [CUM_W:0] s;
        for (int i = 0; i < NUM_CH; i++)
        begin
            s = {cum_reg[i][CUM_W-1], cum_reg[i]}
                + {{(CUM_W+1-SHIFT_W){shift_in[i][SHIFT_W-1]}}, shift_in[i]};
            if (s[CUM_W] != s[CUM_W-1])
                cum_next[i] = s[CUM_W] ? CUM_MIN : CUM_MAX;
            else
                cum_next[i] = s[CUM_W-1:0];
        end
    end

    assign wr_data = {cum_next[0], cum_next[1], cum_next[2]};
    assign rd_addr = wp_reg - ADDR_W'(1) - ctl.rd_back;

    // Trajectory control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
                cum_reg[i] <= '0;
            fs_reg  <= '0;
            wp_reg  <= '0;
            tag_reg <= TAG_NONE;
        end
        else
        begin
            tag_reg <= ctl.rd_en ? ctl.rd_tag : TAG_NONE;
            if (ctl.seq_clear)
            begin
                for (int i = 0; i < NUM_CH; i++)
                    cum_reg[i] <= '0;
                fs_reg <= '0;
                wp_reg <= '0;
            end
            else if (ctl.cap_in)
            begin
                for (int i = 0; i < NUM_CH; i++)
                    cum_reg[i] <= cum_next[i];
                wp_reg <= wp_reg + ADDR_W'(1);
                if (fs_reg != {FS_W{1'b1}})
                    fs_reg <= fs_reg + FS_W'(1);
            end
        end
    end

    // Ring memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.cap_in)
            ring[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
            rd_data_reg <= ring[rd_addr];
    end

    // Window accumulators and previous point
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (ctl.clr_acc)
            begin
                sum_reg[i]  <= '0;
                prev_reg[i] <= '0;
            end
            else if (tag_reg == TAG_SUM)
            begin
                sum_reg[i] <= sum_reg[i] + SUM_W'(signed'(
                    rd_data_reg[(NUM_CH-1-i)*CUM_W +: CUM_W]));
            end
            else if (tag_reg == TAG_PREV)
            begin
                prev_reg[i] <= rd_data_reg[(NUM_CH-1-i)*CUM_W +: CUM_W];
            end
        end
    end

    // Rounded magnitude feeds the shared divider
    always_comb
    begin
        sel_sum  = sum_reg[ctl.ch];
        sel_prev = prev_reg[ctl.ch];
        mag      = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
        dividend = mag + SUM_W'(ctl.count >> 1);
    end

    tsc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (dividend),
        .divisor  (ctl.count),
        .done     (div_done),
        .quotient (quotient)
    );

    // Restore sign, subtract previous point, saturate
    always_comb
    begin
        q_signed = sel_sum[SUM_W-1] ? -$signed({1'b0, quotient})
                                    :  $signed({1'b0, quotient});
        diff = (SUM_W+2)'(q_signed) - (SUM_W+2)'(sel_prev);
        if (diff > (SUM_W+2)'(OUT_MAX))
            diff_sat = OUT_MAX;
        else if (diff < (SUM_W+2)'(OUT_MIN))
            diff_sat = OUT_MIN;
        else
            diff_sat = diff[OUT_W-1:0];
    end

    // Result and output payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.res_load)
            res_reg[ctl.ch] <= diff_sat;
        if (ctl.out_load)
        begin
            for (int i = 0; i < NUM_CH; i++)
                out_reg[i] <= res_reg[i];
            last_reg <= ctl.out_last;
        end
    end

    assign sts.frames_seen   = fs_reg;
    assign sts.div_done      = div_done;
    assign corrected_x        = out_reg[0];
    assign corrected_y        = out_reg[1];
    assign corrected_rotation = out_reg[2];
    assign end_of_run         = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/tsc_ctrl.sv */
// ============================================================================
// tsc_ctrl - sequencer
// Plans each result window, walks the ring reads, runs the divider over the
// three channels and hands results to the output register.
// ============================================================================
`default_nettype none

module tsc_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [tsc_pkg::RAD_W-1:0]  radius,
    input  wire tsc_pkg::sts_t              sts,
    input  wire logic                       in_valid,
    input  wire logic                       final_frame,
    output logic                            in_ready,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output tsc_pkg::ctl_t                   ctl
);
    import tsc_pkg::*;

    state_t             state_reg, state_next;
    logic               fin_reg, fin_next;
    logic [RAD_W-1:0]   d_reg, d_next;
    logic [ADDR_W-1:0]  hi_reg, hi_next;
    logic [ADDR_W-1:0]  b_reg, b_next;
    logic [1:0]         ch_reg, ch_next;
    logic               ov_reg, ov_next;
    logic [FS_W-1:0]    fsm1;
    logic [FS_W-1:0]    r7;
    logic [FS_W-1:0]    span;
    logic [FS_W-1:0]    back7;
    logic               out_free;

    always_comb
    begin
        fsm1     = sts.frames_seen - FS_W'(1);
        r7       = FS_W'(radius);
        span     = FS_W'(d_reg) + r7;
        back7    = FS_W'(d_reg) + FS_W'(1);
        out_free = !ov_reg || out_ready;
    end

    // Next state and controls
    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        d_next     = d_reg;
        hi_next    = hi_reg;
        b_next     = b_reg;
        ch_next    = ch_reg;
        ov_next    = ov_reg && !out_ready;
        in_ready   = 1'b0;

        ctl           = '0;
        ctl.rd_tag    = TAG_NONE;
        ctl.count     = hi_reg + ADDR_W'(1);
        ctl.ch        = ch_reg;
        ctl.rd_back   = b_reg;
        ctl.out_last  = fin_reg && (d_reg == '0);

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.cap_in = 1'b1;
                    fin_next   = final_frame;
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN:
            begin
                if (!fin_reg)
                begin
                    if (fsm1 >= r7)
                    begin
                        d_next     = radius;
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    d_next     = (fsm1 > r7) ? radius : fsm1[RAD_W-1:0];
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                // window runs from the newest point back to d + r, clipped
                hi_next     = (span > fsm1) ? fsm1[ADDR_W-1:0] : span[ADDR_W-1:0];
                b_next      = '0;
                ch_next     = CH_X;
                ctl.clr_acc = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_tag = TAG_SUM;
                if (b_reg == hi_reg)
                    state_next = ST_PREV;
                else
                    b_next = b_reg + ADDR_W'(1);
            end
            ST_PREV:
            begin
                // previous point exists only inside the sequence
                ctl.rd_back = back7[ADDR_W-1:0];
                if (back7 <= fsm1)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_tag = TAG_PREV;
                end
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                ctl.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    ctl.res_load = 1'b1;
                    if (ch_reg == CH_A)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ctl.out_load = 1'b1;
                    ov_next      = 1'b1;
                    if (fin_reg && (d_reg != '0))
                    begin
                        d_next     = d_reg - RAD_W'(1);
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        ctl.seq_clear = fin_reg;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            d_reg     <= '0;
            hi_reg    <= '0;
            b_reg     <= '0;
            ch_reg    <= CH_X;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            d_reg     <= d_next;
            hi_reg    <= hi_next;
            b_reg     <= b_next;
            ch_reg    <= ch_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule

`default_nettype wire

/* hw/rtl/trajectory_smoothing_correction.sv */
// ============================================================================
// trajectory_smoothing_correction - moving-average trajectory stabilizer
// Accumulates per-frame motion into a trajectory, box-averages it over a
// centered window and emits the corrected motion per frame.
// ============================================================================
//
//  channel   direction  transfer when            payload
//  -------   ---------  -----------------------  ------------------------------
//  in        sink       in_valid && in_ready     shift_x, shift_y, rotation,
//                                                final_frame
//  out       source     out_valid && out_ready   corrected_x, corrected_y,
//                                                corrected_rotation, end_of_run
//  cfg       sink       cfg_valid && cfg_ready   cfg_data = smoothing radius
//
//  An item that emits nothing passes through accept and plan. Each result
//  passes through setup, W ring reads on the single read port (W being the
//  window length, up to 63), the previous-point read and drain, three runs
//  of the shared one-bit-per-cycle divider, then the output load.
//  A final frame emits up to radius + 1 results back to back.
//  Reset is asynchronous; the ring needs no clearing pass. A stalled output
//  holds its result while the next input transfer is taken; the sequencer
//  waits before loading the next result until the output register is free.
//
`default_nettype none

module trajectory_smoothing_correction (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [tsc_pkg::SHIFT_W-1:0] shift_x,
    input  wire logic signed [tsc_pkg::SHIFT_W-1:0] shift_y,
    input  wire logic signed [tsc_pkg::SHIFT_W-1:0] rotation,
    input  wire logic                               final_frame,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [tsc_pkg::OUT_W-1:0]        corrected_x,
    output logic signed [tsc_pkg::OUT_W-1:0]        corrected_y,
    output logic signed [tsc_pkg::OUT_W-1:0]        corrected_rotation,
    output logic                                    end_of_run,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tsc_pkg::RAD_W-1:0]          cfg_data
);
    import tsc_pkg::*;

    logic [RAD_W-1:0] radius_reg;
    logic [RAD_W-1:0] radius_eff;
    ctl_t             ctl;
    sts_t             sts;

    // Radius register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (cfg_valid)
            radius_reg <= cfg_data;
    end

    // Clamp to the supported radius
    assign radius_eff = (FS_W'(radius_reg) > MAX_RADIUS) ? MAX_RADIUS[RAD_W-1:0]
                                                         : radius_reg;

    tsc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .radius      (radius_eff),
        .sts         (sts),
        .in_valid    (in_valid),
        .final_frame (final_frame),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ctl         (ctl)
    );

    tsc_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .shift_x            (shift_x),
        .shift_y            (shift_y),
        .rotation           (rotation),
        .sts                (sts),
        .corrected_x        (corrected_x),
        .corrected_y        (corrected_y),
        .corrected_rotation (corrected_rotation),
        .end_of_run         (end_of_run)
    );

endmodule

`default_nettype wire

/* hw/rtl/tsc_checker.sv */
// ============================================================================
// tsc_checker - port-level checks for trajectory smoothing correction
// Watches the top-level handshakes and the busy behavior of the sequencer.
// ============================================================================
`default_nettype none

module tsc_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic signed [tsc_pkg::SHIFT_W-1:0] shift_x,
    input  wire logic signed [tsc_pkg::SHIFT_W-1:0] shift_y,
    input  wire logic signed [tsc_pkg::SHIFT_W-1:0] rotation,
    input  wire logic                               final_frame,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic signed [tsc_pkg::OUT_W-1:0]   corrected_x,
    input  wire logic signed [tsc_pkg::OUT_W-1:0]   corrected_y,
    input  wire logic signed [tsc_pkg::OUT_W-1:0]   corrected_rotation,
    input  wire logic                               end_of_run,
    input  wire logic                               cfg_valid,
    input  wire logic                               cfg_ready,
    input  wire logic [tsc_pkg::RAD_W-1:0]          cfg_data
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(corrected_x)
            && $stable(corrected_y) && $stable(corrected_rotation)
            && $stable(end_of_run))
        else $error("output changed while stalled");

    // A waiting input transfer keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(shift_x)
            && $stable(shift_y) && $stable(rotation) && $stable(final_frame))
        else $error("input changed while waiting");

    // A waiting register write keeps its data
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && !cfg_ready |=> cfg_valid && $stable(cfg_data))
        else $error("register write changed while waiting");

    // An input transfer always starts a busy period
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after an input transfer");

    // A new result is only produced while the input side is closed
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

endmodule

bind trajectory_smoothing_correction tsc_checker u_chk (.*);

`default_nettype wire
